### hdl/ows_pkg.sv
// Shared types, codes and the CRC-8 step function for the ROM search engine.
package ows_pkg;

    localparam int unsigned RomWidth  = 64;
    localparam int unsigned PosWidth  = 7;
    localparam int unsigned CrcWidth  = 8;
    localparam logic [CrcWidth-1:0] CrcPoly = 8'h8C;
    localparam logic [PosWidth-1:0] FirstPos = 7'd1;
    localparam logic [PosWidth:0]   EndPos   = 8'd65;

    // Item kinds
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_START  = 2'd1,
        MODE_BIT    = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    // Result codes
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_ACCEPT    = 3'd1,
        ST_FOUND     = 3'd2,
        ST_END       = 3'd3,
        ST_NO_PRES   = 3'd4,
        ST_BIT_FAIL  = 3'd5,
        ST_CRC_FAIL  = 3'd6
    } status_t;

    // Search state carried between beats
    typedef struct packed {
        logic [RomWidth-1:0] rom;
        logic [PosWidth-1:0] last_disc;
        logic [PosWidth-1:0] last_zero;
        logic [PosWidth-1:0] bit_pos;
        logic [CrcWidth-1:0] crc;
        logic                last_flag;
        logic                pass_active;
    } search_state_t;

    // One result beat
    typedef struct packed {
        status_t             status;
        logic                write_valid;
        logic                write_bit;
        logic [RomWidth-1:0] rom_code;
        logic                last_device;
    } result_t;

    localparam search_state_t StateReset = '{
        rom:         '0,
        last_disc:   '0,
        last_zero:   '0,
        bit_pos:     FirstPos,
        crc:         '0,
        last_flag:   1'b0,
        pass_active: 1'b0
    };

    // Reflected CRC-8 over one byte, LSB first
    function automatic logic [CrcWidth-1:0] crc8_byte(input logic [CrcWidth-1:0] crc_in,
                                                      input logic [7:0] data);
        logic [CrcWidth-1:0] c;
        logic [7:0]          d;
        logic                fb;
        c = crc_in;
        d = data;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[0];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CrcPoly;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

### hdl/ows_step.sv
// Combinational next-state and result logic for one search beat.
module ows_step (
    input  logic [1:0]             mode,
    input  logic                   presence,
    input  logic                   id_bit,
    input  logic                   cmp_bit,
    input  ows_pkg::search_state_t cur,
    output ows_pkg::search_state_t nxt,
    output ows_pkg::result_t       res
);

    logic [ows_pkg::PosWidth-1:0] bp;
    logic [5:0]                   idx;
    logic [2:0]                   byte_idx;
    logic [ows_pkg::PosWidth:0]   bp_inc;
    logic                         dir;
    ows_pkg::mode_t               mode_e;

    assign mode_e   = ows_pkg::mode_t'(mode);
    assign bp       = cur.bit_pos;
    assign idx      = 6'(bp - 7'd1);
    assign byte_idx = 3'(bp[5:3] - 3'd1);
    assign bp_inc   = {1'b0, bp} + 8'd1;

    // Direction choice: forced by the bus, else follow the previous code below the last discrepancy, 1 at it, 0 beyond
    always_comb begin
        if (id_bit != cmp_bit) begin
            dir = id_bit;
        end else if (bp < cur.last_disc) begin
            dir = cur.rom[idx];
        end else begin
            dir = (bp == cur.last_disc);
        end
    end

    always_comb begin
        nxt             = cur;
        res.status      = ows_pkg::ST_IDLE;
        res.write_valid = 1'b0;
        res.write_bit   = 1'b0;
        res.last_device = 1'b0;
        case (mode_e)
            ows_pkg::MODE_CLEAR: begin
                nxt = ows_pkg::StateReset;
            end
            ows_pkg::MODE_START: begin
                if (cur.last_flag || !presence) begin
                    nxt.last_disc   = '0;
                    nxt.last_flag   = 1'b0;
                    nxt.pass_active = 1'b0;
                    res.status      = cur.last_flag ? ows_pkg::ST_END : ows_pkg::ST_NO_PRES;
                end else begin
                    nxt.pass_active = 1'b1;
                    nxt.bit_pos     = ows_pkg::FirstPos;
                    nxt.last_zero   = '0;
                    nxt.crc         = '0;
                    res.status      = ows_pkg::ST_ACCEPT;
                end
            end
            ows_pkg::MODE_BIT: begin
                if (cur.pass_active) begin
                    if (id_bit && cmp_bit) begin
                        nxt.last_disc   = '0;
                        nxt.last_flag   = 1'b0;
                        nxt.pass_active = 1'b0;
                        res.status      = ows_pkg::ST_BIT_FAIL;
                    end else begin
                        if ((id_bit == cmp_bit) && !dir) begin
                            nxt.last_zero = bp;
                        end
                        nxt.rom[idx]    = dir;
                        res.write_valid = 1'b1;
                        res.write_bit   = dir;
                        res.status      = ows_pkg::ST_ACCEPT;
                        // CRC byte closes on every eighth bit
                        if ((bp[2:0] == 3'd0) && (bp >= 7'd8)) begin
                            nxt.crc = ows_pkg::crc8_byte(cur.crc,
                                                         nxt.rom[{byte_idx, 3'b000} +: 8]);
                        end
                        nxt.bit_pos = bp_inc[ows_pkg::PosWidth-1:0];
                        // Final bit: check CRC and family byte
                        if (bp_inc >= ows_pkg::EndPos) begin
                            nxt.pass_active = 1'b0;
                            if ((nxt.crc == '0) && (nxt.rom[7:0] != 8'd0)) begin
                                nxt.last_disc   = nxt.last_zero;
                                nxt.last_flag   = (nxt.last_zero == '0);
                                res.status      = ows_pkg::ST_FOUND;
                                res.last_device = (nxt.last_zero == '0);
                            end else begin
                                nxt.last_disc = '0;
                                nxt.last_flag = 1'b0;
                                res.status    = ows_pkg::ST_CRC_FAIL;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.rom_code = nxt.rom;
    end

endmodule

### hdl/onewire_rom_search.sv
// Top level of the 1-Wire search-ROM engine: input register, state and result register.
// Path: input register, then the step logic that updates the state, then result register.
// Throughput: one item per cycle while m_ready does not stall the result register.
// A stalled result holds the result register; the input register still takes one beat.
// Reset: synchronous, active low; clears valids and returns the search state to its start
// (ROM code and CRC zero, bit position one, no pass active).
module onewire_rom_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic        s_presence,
    input  logic        s_id_bit,
    input  logic        s_cmp_bit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_write_valid,
    output logic        m_write_bit,
    output logic [63:0] m_rom_code,
    output logic        m_last_device
);

    logic                   in_valid_reg;
    logic [1:0]             mode_reg;
    logic                   presence_reg;
    logic                   id_bit_reg;
    logic                   cmp_bit_reg;
    logic                   out_valid_reg;
    logic                   advance;
    ows_pkg::search_state_t state_reg;
    ows_pkg::search_state_t state_next;
    ows_pkg::result_t       res_reg;
    ows_pkg::result_t       res_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            mode_reg     <= s_mode;
            presence_reg <= s_presence;
            id_bit_reg   <= s_id_bit;
            cmp_bit_reg  <= s_cmp_bit;
        end
    end

    ows_step u_step (
        .mode     (mode_reg),
        .presence (presence_reg),
        .id_bit   (id_bit_reg),
        .cmp_bit  (cmp_bit_reg),
        .cur      (state_reg),
        .nxt      (state_next),
        .res      (res_next)
    );

    // Search state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ows_pkg::StateReset;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = res_reg.status;
    assign m_write_valid = res_reg.write_valid;
    assign m_write_bit   = res_reg.write_bit;
    assign m_rom_code    = res_reg.rom_code;
    assign m_last_device = res_reg.last_device;

`ifndef SYNTH
    // A write is only ordered with a bit-pair result
    a_write_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_write_valid) |-> (m_status == ows_pkg::ST_ACCEPT ||
                                        m_status == ows_pkg::ST_FOUND ||
                                        m_status == ows_pkg::ST_CRC_FAIL))
        else $error("write ordered with wrong status");

    // Last device flag only with a found device
    a_last_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_device) |-> (m_status == ows_pkg::ST_FOUND))
        else $error("last device without found status");

    // An active pass keeps its bit position within the ROM code
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pass_active |-> (state_reg.bit_pos >= 7'd1 && state_reg.bit_pos <= 7'd64))
        else $error("bit position out of range during pass");

    // A held result beat keeps its payload when it is not taken
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rom_code) && $stable(m_status)))
        else $error("result beat changed while stalled");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the 1-Wire search-ROM engine, driving an emulated bus of devices.
module testbench;

    localparam int ItemTarget = 1350;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = ows_pkg::MODE_CLEAR;
    logic        s_presence = 1'b0;
    logic        s_id_bit = 1'b0;
    logic        s_cmp_bit = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_write_valid;
    logic        m_write_bit;
    logic [63:0] m_rom_code;
    logic        m_last_device;

    // Predicted search state, reset values
    logic [63:0] srch_rom = '0;
    logic [6:0]  srch_last_disc = '0;
    logic [6:0]  srch_last_zero = '0;
    logic [6:0]  srch_pos = ows_pkg::FirstPos;
    logic [7:0]  srch_crc = '0;
    logic        srch_last = 1'b0;
    logic        srch_active = 1'b0;

    ows_pkg::result_t expected_results [$];
    logic [63:0]      bus_roms [$];
    bit               calm = 1'b0;
    int               mismatches = 0;
    int               beats_checked = 0;
    int               live_items = 0;
    int               passes = 0;
    int               status_count [8];

    onewire_rom_search uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_presence    (s_presence),
        .s_id_bit      (s_id_bit),
        .s_cmp_bit     (s_cmp_bit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_write_valid (m_write_valid),
        .m_write_bit   (m_write_bit),
        .m_rom_code    (m_rom_code),
        .m_last_device (m_last_device)
    );

    // 20-unit clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Reflected CRC-8, one byte LSB first
    function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
        for (int i = 0; i < 8; i++) begin
            if (crc[0] ^ data[0]) begin
                crc = (crc >> 1) ^ ows_pkg::CrcPoly;
            end else begin
                crc = crc >> 1;
            end
            data = data >> 1;
        end
        return crc;
    endfunction

    // ROM code with a correct check byte on top
    function automatic logic [63:0] make_rom(logic [7:0] family, logic [47:0] serial);
        logic [55:0] body;
        logic [7:0]  crc;
        body = {serial, family};
        crc  = '0;
        for (int i = 0; i < 7; i++) begin
            crc = crc8_update(crc, body[i*8 +: 8]);
        end
        return {crc, body};
    endfunction

    // Forget the search path; the ROM code and CRC stay
    function automatic void drop_search();
        srch_last_disc = '0;
        srch_last      = 1'b0;
        srch_active    = 1'b0;
    endfunction

    // Expected result of one item; advances the predicted state
    function automatic ows_pkg::result_t predict_step(ows_pkg::mode_t md, bit pres, bit idb,
                                                      bit cmpb);
        ows_pkg::result_t r;
        int               bp;
        bit               dir;
        r = '0;
        r.status = ows_pkg::ST_IDLE;
        case (md)
            ows_pkg::MODE_CLEAR: begin
                srch_rom       = '0;
                srch_last_disc = '0;
                srch_last_zero = '0;
                srch_pos       = ows_pkg::FirstPos;
                srch_crc       = '0;
                srch_last      = 1'b0;
                srch_active    = 1'b0;
            end
            ows_pkg::MODE_START: begin
                if (srch_last) begin
                    drop_search();
                    r.status = ows_pkg::ST_END;
                end else if (!pres) begin
                    drop_search();
                    r.status = ows_pkg::ST_NO_PRES;
                end else begin
                    srch_active    = 1'b1;
                    srch_pos       = ows_pkg::FirstPos;
                    srch_last_zero = '0;
                    srch_crc       = '0;
                    r.status       = ows_pkg::ST_ACCEPT;
                end
            end
            ows_pkg::MODE_BIT: begin
                if (srch_active) begin
                    if (idb && cmpb) begin
                        drop_search();
                        r.status = ows_pkg::ST_BIT_FAIL;
                    end else begin
                        bp = srch_pos;
                        if (idb != cmpb) begin
                            dir = idb;
                        end else begin
                            // discrepancy: follow old path, turn at the last one
                            if (bp < srch_last_disc) begin
                                dir = srch_rom[(bp - 1) & 63];
                            end else begin
                                dir = (bp == srch_last_disc);
                            end
                            if (!dir) begin
                                srch_last_zero = 7'(bp);
                            end
                        end
                        srch_rom[(bp - 1) & 63] = dir;
                        r.write_valid = 1'b1;
                        r.write_bit   = dir;
                        r.status      = ows_pkg::ST_ACCEPT;
                        if (bp % 8 == 0) begin
                            srch_crc = crc8_update(srch_crc, srch_rom[((bp - 8) & 63) +: 8]);
                        end
                        bp++;
                        srch_pos = 7'(bp);
                        // end of the 64 bits: judge CRC and family byte
                        if (bp >= 65) begin
                            srch_active = 1'b0;
                            if (srch_crc == '0 && srch_rom[7:0] != '0) begin
                                srch_last_disc = srch_last_zero;
                                srch_last      = (srch_last_zero == '0);
                                r.status       = ows_pkg::ST_FOUND;
                                r.last_device  = srch_last;
                            end else begin
                                drop_search();
                                r.status = ows_pkg::ST_CRC_FAIL;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        r.rom_code = srch_rom;
        status_count[int'(r.status)]++;
        return r;
    endfunction

    // Send one beat, with random idle cycles ahead of it outside the calm round
    task automatic send_item(input ows_pkg::mode_t md, input bit pres, input bit idb,
                             input bit cmpb, output ows_pkg::result_t exp);
        while (!calm && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= md;
        s_presence <= pres;
        s_id_bit   <= idb;
        s_cmp_bit  <= cmpb;
        do @(posedge aclk); while (!s_ready);
        exp = predict_step(md, pres, idb, cmpb);
        expected_results.push_back(exp);
        if (exp.status != ows_pkg::ST_IDLE || md == ows_pkg::MODE_CLEAR) begin
            live_items++;
        end
    endtask

    // One search pass over the emulated bus; break_at forces both bits high at that bit
    task automatic run_pass(input bit pres, input int break_at,
                            output ows_pkg::status_t final_st);
        ows_pkg::result_t r;
        bit               alive [$];
        bit               idb;
        bit               cmpb;
        foreach (bus_roms[d]) begin
            alive.push_back(1'b1);
        end
        passes++;
        send_item(ows_pkg::MODE_START, pres, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), r);
        final_st = r.status;
        if (r.status != ows_pkg::ST_ACCEPT) begin
            return;
        end
        for (int pos = 0; pos < 64; pos++) begin
            // wired-AND of the devices still on the path
            idb  = 1'b1;
            cmpb = 1'b1;
            foreach (bus_roms[d]) begin
                if (alive[d]) begin
                    idb  &= bus_roms[d][pos];
                    cmpb &= !bus_roms[d][pos];
                end
            end
            if (pos == break_at) begin
                idb  = 1'b1;
                cmpb = 1'b1;
            end
            if ($urandom_range(0, 99) < 2) begin
                send_item(ows_pkg::MODE_UNUSED, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r);
            end
            send_item(ows_pkg::MODE_BIT, 1'($urandom_range(0, 1)), idb, cmpb, r);
            final_st = r.status;
            if (!r.write_valid) begin
                return;
            end
            foreach (bus_roms[d]) begin
                if (bus_roms[d][pos] != r.write_bit) begin
                    alive[d] = 1'b0;
                end
            end
        end
    endtask

    // Random device set; flaw 1 spoils one check byte, flaw 2 zeroes one family byte
    task automatic build_devices(input int count, input int flaw);
        logic [7:0]  set_family;
        logic [7:0]  family;
        logic [47:0] serial;
        int          k;
        bus_roms.delete();
        set_family = 8'($urandom_range(1, 255));
        for (int n = 0; n < count; n++) begin
            family = set_family;
            if (n > 0 && $urandom_range(0, 1)) begin
                // near neighbour of an earlier device: its serial with one bit flipped
                serial    = bus_roms[$urandom_range(0, n - 1)][55:8];
                k         = int'($urandom_range(0, 47));
                serial[k] = ~serial[k];
            end else begin
                serial = {16'($urandom), $urandom};
                if ($urandom_range(0, 3) == 0) begin
                    family = 8'($urandom_range(1, 255));
                end
            end
            bus_roms.push_back(make_rom(family, serial));
        end
        if (flaw == 1) begin
            k = int'($urandom_range(56, 63));
            bus_roms[count - 1][k] = ~bus_roms[count - 1][k];
        end else if (flaw == 2) begin
            bus_roms[count - 1] = make_rom(8'h00, bus_roms[count - 1][55:8]);
        end
    endtask

    // Full enumeration from a cleared state, with passes broken at random per noise_pct
    task automatic enumerate(input int noise_pct);
        ows_pkg::result_t r;
        ows_pkg::status_t st;
        int               tries;
        int               brk;
        bit               pres;
        send_item(ows_pkg::MODE_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), r);
        tries = 0;
        do begin
            brk  = ($urandom_range(0, 99) < noise_pct) ? int'($urandom_range(0, 63)) : -1;
            pres = (int'($urandom_range(0, 99)) >= noise_pct / 2);
            run_pass(pres, brk, st);
            tries++;
        end while (st != ows_pkg::ST_END && tries < 2 * bus_roms.size() + 4);
    endtask

    // Unused mode and bit pairs outside a pass are ignored; a clear follows
    task automatic test_ignored_items();
        ows_pkg::result_t r;
        send_item(ows_pkg::MODE_UNUSED, 1'b1, 1'b1, 1'b1, r);
        send_item(ows_pkg::MODE_BIT, 1'b1, 1'b0, 1'b1, r);
        send_item(ows_pkg::MODE_UNUSED, 1'b0, 1'b0, 1'b0, r);
        send_item(ows_pkg::MODE_CLEAR, 1'b1, 1'b1, 1'b1, r);
    endtask

    // Presence, each bit-pair kind, restart mid-pass and clear mid-pass
    task automatic test_pass_control();
        ows_pkg::result_t r;
        send_item(ows_pkg::MODE_START, 1'b0, 1'b1, 1'b0, r);
        send_item(ows_pkg::MODE_START, 1'b1, 1'b0, 1'b1, r);
        send_item(ows_pkg::MODE_BIT, 1'b0, 1'b1, 1'b0, r);
        send_item(ows_pkg::MODE_BIT, 1'b1, 1'b0, 1'b1, r);
        send_item(ows_pkg::MODE_BIT, 1'b0, 1'b0, 1'b0, r);
        send_item(ows_pkg::MODE_BIT, 1'b1, 1'b1, 1'b1, r);
        send_item(ows_pkg::MODE_BIT, 1'b0, 1'b0, 1'b1, r);
        send_item(ows_pkg::MODE_START, 1'b1, 1'b1, 1'b1, r);
        repeat (3) send_item(ows_pkg::MODE_BIT, 1'b0, 1'b0, 1'b0, r);
        send_item(ows_pkg::MODE_START, 1'b1, 1'b0, 1'b0, r);
        send_item(ows_pkg::MODE_BIT, 1'b1, 1'b1, 1'b0, r);
        send_item(ows_pkg::MODE_CLEAR, 1'b0, 1'b0, 1'b0, r);
        send_item(ows_pkg::MODE_BIT, 1'b0, 1'b0, 1'b0, r);
    endtask

    // Single devices at the extremes: found, then end of list, then found again
    task automatic test_single_device();
        ows_pkg::result_t r;
        ows_pkg::status_t st;
        bus_roms.delete();
        bus_roms.push_back(make_rom(8'hFF, '1));
        send_item(ows_pkg::MODE_CLEAR, 1'b0, 1'b0, 1'b0, r);
        repeat (3) run_pass(1'b1, -1, st);
        bus_roms.delete();
        bus_roms.push_back(make_rom(8'h01, '0));
        send_item(ows_pkg::MODE_CLEAR, 1'b0, 1'b0, 1'b0, r);
        run_pass(1'b1, -1, st);
    endtask

    // Pass endings that fail: bad check byte, zero family, both bits high on the last bit
    task automatic test_bad_endings();
        ows_pkg::status_t st;
        build_devices(1, 1);
        run_pass(1'b1, -1, st);
        build_devices(1, 2);
        run_pass(1'b1, -1, st);
        build_devices(2, 0);
        run_pass(1'b1, 63, st);
        run_pass(1'b1, -1, st);
    endtask

    // Random device sets, mostly well-formed searches, one round without idling
    task automatic test_enumeration();
        int round;
        round = 0;
        while (live_items < ItemTarget) begin
            calm = (round == 1);
            build_devices(int'($urandom_range(1, 6)),
                          ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 2)) : 0);
            enumerate(calm ? 0 : 8);
            round++;
        end
        calm = 1'b0;
    endtask

    // Result side stalls at random
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 24);
    end

    task automatic compare_field(input string fname, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", fname, want, got);
            mismatches++;
        end
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge aclk) begin
        ows_pkg::result_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no expectation waiting");
                mismatches++;
            end else begin
                exp = expected_results.pop_front();
                beats_checked++;
                compare_field("status", 64'(exp.status), 64'(m_status));
                compare_field("write_valid", 64'(exp.write_valid), 64'(m_write_valid));
                compare_field("write_bit", 64'(exp.write_bit), 64'(m_write_bit));
                compare_field("rom_code", exp.rom_code, m_rom_code);
                compare_field("last_device", 64'(exp.last_device), 64'(m_last_device));
            end
        end
    end

    // Test sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_ignored_items();
        test_pass_control();
        test_single_device();
        test_bad_endings();
        test_enumeration();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("summary: %0d beats checked over %0d passes, %0d devices found, %0d end of list",
                 beats_checked, passes, status_count[ows_pkg::ST_FOUND],
                 status_count[ows_pkg::ST_END]);
        $display("summary: %0d no presence, %0d bit failures, %0d CRC failures, %0d mismatches",
                 status_count[ows_pkg::ST_NO_PRES], status_count[ows_pkg::ST_BIT_FAIL],
                 status_count[ows_pkg::ST_CRC_FAIL], mismatches);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #(20 * 500000);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
